// ===== src/vna_pkg.sv =====
// Shared types and constants for the vertex normal accumulator.
// Depends on nothing; imported by vna_sqrtdiv and vertex_normal_accumulator_core.
package vna_pkg;

    // Default configuration values for the top-level parameters.
    localparam int MAX_VERTICES_DEF     = 1024;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    // Fixed field widths of the command channel.
    localparam int IDX_W = 10;
    localparam int POS_W = 24;

    // Magnitudes are scaled below 2^MAG_W before squaring.
    localparam int MAG_W = 30;
    // Width of the sum of squares and of the square-root working registers.
    localparam int SQ_W  = 64;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_TRI   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

endpackage

// ===== src/vna_sqrtdiv.sv =====
// Iterative square root and restoring divider used for vector normalization.
// Depends on vna_pkg; the square root and the divider each resolve one bit per cycle.
module vna_sqrtdiv import vna_pkg::*; #(
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [SQ_W-1:0]             sum_sq,
    input  logic [MAG_W-1:0]            mag [3],
    output logic                        done,
    output logic [NORMAL_FRAC_BITS:0]   quot [3]
);

    localparam int NUM_W  = MAG_W + NORMAL_FRAC_BITS + 1;
    localparam int ROOT_W = 32;
    localparam int REM_W  = ROOT_W + 1;
    localparam int CNT_W  = $clog2(NORMAL_FRAC_BITS + 2);

    typedef enum logic [2:0] {
        SD_IDLE,
        SD_ROOT,
        SD_LOAD,
        SD_DIV,
        SD_DONE
    } sd_state_t;

    sd_state_t                  state_reg;
    logic [SQ_W-1:0]            n_reg;
    logic [SQ_W-1:0]            res_reg;
    logic [SQ_W-1:0]            bit_reg;
    logic [ROOT_W-1:0]          root_reg;
    logic [REM_W-1:0]           rem_reg;
    logic [NORMAL_FRAC_BITS:0]  low_reg;
    logic [NORMAL_FRAC_BITS:0]  q_reg [3];
    logic [1:0]                 j_reg;
    logic [CNT_W-1:0]           cnt_reg;

    logic [SQ_W-1:0]            trial;
    logic                       take_root;
    logic [SQ_W-1:0]            res_next;
    logic [MAG_W-1:0]           mag_sel;
    logic [NUM_W-1:0]           num;
    logic [REM_W-1:0]           rem_shift;
    logic                       take_div;

    // One step of the digit-by-digit square root.
    always_comb begin
        trial     = res_reg + bit_reg;
        take_root = (n_reg >= trial);
        res_next  = take_root ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
    end

    // Numerator with rounding term, and one restoring division step.
    always_comb begin
        case (j_reg)
            2'd0:    mag_sel = mag[0];
            2'd1:    mag_sel = mag[1];
            default: mag_sel = mag[2];
        endcase
        num       = NUM_W'({mag_sel, {NORMAL_FRAC_BITS{1'b0}}}) + NUM_W'(root_reg >> 1);
        rem_shift = {rem_reg[REM_W-2:0], low_reg[NORMAL_FRAC_BITS]};
        take_div  = (rem_shift >= {1'b0, root_reg});
    end

    // Sequencer and datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SD_IDLE;
        end else begin
            case (state_reg)
                SD_IDLE: begin
                    if (start) begin
                        n_reg     <= sum_sq;
                        res_reg   <= '0;
                        bit_reg   <= SQ_W'(1) << (SQ_W - 2);
                        state_reg <= SD_ROOT;
                    end
                end
                SD_ROOT: begin
                    if (take_root) begin
                        n_reg <= n_reg - trial;
                    end
                    res_reg <= res_next;
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg == SQ_W'(1)) begin
                        root_reg  <= res_next[ROOT_W-1:0];
                        j_reg     <= 2'd0;
                        state_reg <= SD_LOAD;
                    end
                end
                SD_LOAD: begin
                    rem_reg   <= REM_W'(num >> (NORMAL_FRAC_BITS + 1));
                    low_reg   <= num[NORMAL_FRAC_BITS:0];
                    cnt_reg   <= '0;
                    state_reg <= SD_DIV;
                end
                SD_DIV: begin
                    rem_reg      <= take_div ? (rem_shift - {1'b0, root_reg}) : rem_shift;
                    low_reg      <= low_reg << 1;
                    q_reg[j_reg] <= {q_reg[j_reg][NORMAL_FRAC_BITS-1:0], take_div};
                    cnt_reg      <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(NORMAL_FRAC_BITS)) begin
                        if (j_reg == 2'd2) begin
                            state_reg <= SD_DONE;
                        end else begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= SD_LOAD;
                        end
                    end
                end
                SD_DONE: begin
                    state_reg <= SD_IDLE;
                end
                default: begin
                    state_reg <= SD_IDLE;
                end
            endcase
        end
    end

    assign done = (state_reg == SD_DONE);
    assign quot = q_reg;

endmodule

// ===== src/vertex_normal_accumulator_core.sv =====
// Vertex normal accumulator: stores, command sequencer and shared multiplier; uses vna_pkg, vna_sqrtdiv.
// A write goes straight to the output; a read or a triangle normalizes its vector through the bit-serial
// square root and divider, which a zero normal or a degenerate triangle skips; a clear sweeps the normal
// store. One transaction at a time; s_ready rises with m_valid. After reset s_ready stays low while
// the normal store is swept.
module vertex_normal_accumulator_core import vna_pkg::*; #(
    parameter int MAX_VERTICES     = MAX_VERTICES_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_command,
    input  logic [IDX_W-1:0]                     s_index_a,
    input  logic [IDX_W-1:0]                     s_index_b,
    input  logic [IDX_W-1:0]                     s_index_c,
    input  logic signed [POS_W-1:0]              s_pos_x,
    input  logic signed [POS_W-1:0]              s_pos_y,
    input  logic signed [POS_W-1:0]              s_pos_z,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [NORMAL_FRAC_BITS+1:0]   m_normal_x,
    output logic signed [NORMAL_FRAC_BITS+1:0]   m_normal_y,
    output logic signed [NORMAL_FRAC_BITS+1:0]   m_normal_z,
    output logic                                 m_status
);

    localparam int AW      = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW      = NORMAL_FRAC_BITS + 2;
    localparam int NMW     = 3 * NW + 1;
    localparam int PMW     = 3 * POS_W;
    localparam int DIFF_W  = POS_W + 1;
    localparam int CROSS_W = 2 * DIFF_W + 1;
    localparam int MUL_W   = 32;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_PA,
        ST_PB,
        ST_PC,
        ST_DIFF,
        ST_CROSS,
        ST_NRD,
        ST_NLOAD,
        ST_ABS,
        ST_SHIFT,
        ST_SQ,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_CRD,
        ST_CWR,
        ST_CLEAR,
        ST_OUT
    } state_t;

    // Reduce an index modulo the store depth by conditional subtraction.
    function automatic logic [AW-1:0] idx_reduce(input logic [IDX_W-1:0] v);
        logic [IDX_W:0] t;
        t = {1'b0, v};
        for (int k = IDX_W; k >= 0; k--) begin
            if ((MAX_VERTICES << k) < (1 << IDX_W)) begin
                if (int'(t) >= (MAX_VERTICES << k)) begin
                    t = t - (IDX_W + 1)'(MAX_VERTICES << k);
                end
            end
        end
        return AW'(t);
    endfunction

    // Stores.
    logic [PMW-1:0] pos_mem [MAX_VERTICES];
    logic [NMW-1:0] nrm_mem [MAX_VERTICES];

    state_t                     state_reg;
    cmd_t                       op_reg;
    logic [AW-1:0]              ia_reg;
    logic [AW-1:0]              ib_reg;
    logic [AW-1:0]              ic_reg;
    logic [AW-1:0]              clr_cnt_reg;
    logic [1:0]                 k_reg;
    logic [2:0]                 cnt_reg;
    logic [PMW-1:0]             pos_q_reg;
    logic [NMW-1:0]             nrm_q_reg;
    logic signed [POS_W-1:0]    p0_reg [3];
    logic signed [POS_W-1:0]    p1_reg [3];
    logic signed [DIFF_W-1:0]   a_reg [3];
    logic signed [DIFF_W-1:0]   b_reg [3];
    logic signed [CROSS_W-1:0]  c_reg [3];
    logic [CROSS_W-1:0]         mag_reg [3];
    logic                       sgn_reg [3];
    logic [SQ_W-1:0]            s_reg;
    logic signed [2*MUL_W-1:0]  prod_reg;
    logic signed [NW-1:0]       u_reg [3];
    logic                       status_reg;
    logic                       m_valid_reg;
    logic signed [NW-1:0]       m_nx_reg;
    logic signed [NW-1:0]       m_ny_reg;
    logic signed [NW-1:0]       m_nz_reg;
    logic                       m_status_reg;

    logic                       accept;
    cmd_t                       cmd_in;
    logic [AW-1:0]              pos_raddr;
    logic [AW-1:0]              nrm_raddr;
    logic [AW-1:0]              corner;
    logic                       nrm_we;
    logic [NMW-1:0]             nrm_wdata;
    logic [AW-1:0]              nrm_waddr;
    logic signed [POS_W-1:0]    pos_f [3];
    logic signed [NW-1:0]       nrm_f [3];
    logic                       nrm_v;
    logic signed [NW-1:0]       nrm_new [3];
    logic signed [NW:0]         nrm_sum [3];
    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [2*MUL_W-1:0]  mul_p;
    logic signed [CROSS_W-1:0]  prod_c;
    logic                       mag_big;
    logic                       c_zero;
    logic                       sd_start;
    logic                       sd_done;
    logic [MAG_W-1:0]           sd_mag [3];
    logic [NORMAL_FRAC_BITS:0]  sd_quot [3];

    assign accept  = s_valid && s_ready;
    assign cmd_in  = cmd_t'(s_command);
    assign s_ready = (state_reg == ST_IDLE);

    // Unpack stored words and form the averaged corner normal.
    always_comb begin
        nrm_v = nrm_q_reg[NMW-1];
        for (int i = 0; i < 3; i++) begin
            pos_f[i]   = pos_q_reg[i*POS_W +: POS_W];
            nrm_f[i]   = nrm_q_reg[i*NW +: NW];
            nrm_sum[i] = (nrm_v ? (NW+1)'(nrm_f[i]) : '0) + (NW+1)'(u_reg[i]);
            nrm_new[i] = nrm_sum[i][NW:1];
            sd_mag[i]  = mag_reg[i][MAG_W-1:0];
        end
    end

    // Corner and read address selection.
    always_comb begin
        case (k_reg)
            2'd0:    corner = ia_reg;
            2'd1:    corner = ib_reg;
            default: corner = ic_reg;
        endcase
        case (state_reg)
            ST_PA:   pos_raddr = ia_reg;
            ST_PB:   pos_raddr = ib_reg;
            default: pos_raddr = ic_reg;
        endcase
        nrm_raddr = (state_reg == ST_CRD) ? corner : ia_reg;
    end

    // Normal store write port: clearing sweep or corner update.
    always_comb begin
        nrm_we    = 1'b0;
        nrm_waddr = corner;
        nrm_wdata = {1'b1, nrm_new[2], nrm_new[1], nrm_new[0]};
        case (state_reg)
            ST_INIT, ST_CLEAR: begin
                nrm_we    = 1'b1;
                nrm_waddr = clr_cnt_reg;
                nrm_wdata = '0;
            end
            ST_CWR: begin
                nrm_we = 1'b1;
            end
            default: begin
                nrm_we = 1'b0;
            end
        endcase
    end

    // Shared multiplier operand selection: cross terms, then squares.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_CROSS) begin
            case (cnt_reg)
                3'd0: begin mul_a = MUL_W'(a_reg[1]); mul_b = MUL_W'(b_reg[2]); end
                3'd1: begin mul_a = MUL_W'(a_reg[2]); mul_b = MUL_W'(b_reg[1]); end
                3'd2: begin mul_a = MUL_W'(a_reg[2]); mul_b = MUL_W'(b_reg[0]); end
                3'd3: begin mul_a = MUL_W'(a_reg[0]); mul_b = MUL_W'(b_reg[2]); end
                3'd4: begin mul_a = MUL_W'(a_reg[0]); mul_b = MUL_W'(b_reg[1]); end
                3'd5: begin mul_a = MUL_W'(a_reg[1]); mul_b = MUL_W'(b_reg[0]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (state_reg == ST_SQ) begin
            case (cnt_reg)
                3'd0: begin
                    mul_a = $signed(MUL_W'(sd_mag[0]));
                    mul_b = $signed(MUL_W'(sd_mag[0]));
                end
                3'd1: begin
                    mul_a = $signed(MUL_W'(sd_mag[1]));
                    mul_b = $signed(MUL_W'(sd_mag[1]));
                end
                3'd2: begin
                    mul_a = $signed(MUL_W'(sd_mag[2]));
                    mul_b = $signed(MUL_W'(sd_mag[2]));
                end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
        mul_p  = mul_a * mul_b;
        prod_c = prod_reg[CROSS_W-1:0];
    end

    // Scaling and zero tests on the vector being normalized.
    always_comb begin
        mag_big = 1'b0;
        c_zero  = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (mag_reg[i][CROSS_W-1:MAG_W] != '0) begin
                mag_big = 1'b1;
            end
            if (c_reg[i] != '0) begin
                c_zero = 1'b0;
            end
        end
    end

    assign sd_start = (state_reg == ST_ROOT_GO);

    vna_sqrtdiv #(
        .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
    ) u_sqrtdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sd_start),
        .sum_sq  (s_reg),
        .mag     (sd_mag),
        .done    (sd_done),
        .quot    (sd_quot)
    );

    // Position store: written on a write transaction, read registered.
    always_ff @(posedge aclk) begin
        if (accept && (cmd_in == CMD_WRITE)) begin
            pos_mem[idx_reduce(s_index_a)] <= {s_pos_z, s_pos_y, s_pos_x};
        end
        pos_q_reg <= pos_mem[pos_raddr];
    end

    // Normal store with its valid flag in the top bit of each word.
    always_ff @(posedge aclk) begin
        if (nrm_we) begin
            nrm_mem[nrm_waddr] <= nrm_wdata;
        end
        nrm_q_reg <= nrm_mem[nrm_raddr];
    end

    // Command sequencer, datapath and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            prod_reg <= mul_p;
            // The output stage reloads the result register itself.
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_INIT: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(MAX_VERTICES - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        op_reg      <= cmd_in;
                        ia_reg      <= idx_reduce(s_index_a);
                        ib_reg      <= idx_reduce(s_index_b);
                        ic_reg      <= idx_reduce(s_index_c);
                        status_reg  <= 1'b0;
                        clr_cnt_reg <= '0;
                        k_reg       <= 2'd0;
                        case (cmd_in)
                            CMD_WRITE: state_reg <= ST_OUT;
                            CMD_TRI:   state_reg <= ST_PA;
                            CMD_READ:  state_reg <= ST_NRD;
                            default:   state_reg <= ST_CLEAR;
                        endcase
                    end
                end
                ST_PA: begin
                    state_reg <= ST_PB;
                end
                ST_PB: begin
                    p0_reg    <= pos_f;
                    state_reg <= ST_PC;
                end
                ST_PC: begin
                    p1_reg    <= pos_f;
                    state_reg <= ST_DIFF;
                end
                ST_DIFF: begin
                    for (int i = 0; i < 3; i++) begin
                        a_reg[i] <= DIFF_W'(p1_reg[i]) - DIFF_W'(p0_reg[i]);
                        b_reg[i] <= DIFF_W'(p1_reg[i]) - DIFF_W'(pos_f[i]);
                    end
                    cnt_reg   <= '0;
                    state_reg <= ST_CROSS;
                end
                ST_CROSS: begin
                    // Product n is issued at step n and folded in at the following step, from the product register.
                    cnt_reg <= cnt_reg + 1'b1;
                    case (cnt_reg)
                        3'd1: c_reg[0] <= prod_c;
                        3'd2: c_reg[0] <= c_reg[0] - prod_c;
                        3'd3: c_reg[1] <= prod_c;
                        3'd4: c_reg[1] <= c_reg[1] - prod_c;
                        3'd5: c_reg[2] <= prod_c;
                        3'd6: c_reg[2] <= c_reg[2] - prod_c;
                        default: c_reg[0] <= c_reg[0];
                    endcase
                    if (cnt_reg == 3'd6) begin
                        state_reg <= ST_ABS;
                    end
                end
                ST_NRD: begin
                    state_reg <= ST_NLOAD;
                end
                ST_NLOAD: begin
                    for (int i = 0; i < 3; i++) begin
                        c_reg[i] <= nrm_v ? CROSS_W'(nrm_f[i]) : '0;
                    end
                    state_reg <= ST_ABS;
                end
                ST_ABS: begin
                    for (int i = 0; i < 3; i++) begin
                        sgn_reg[i] <= c_reg[i][CROSS_W-1];
                        mag_reg[i] <= c_reg[i][CROSS_W-1] ? CROSS_W'(-c_reg[i])
                                                          : CROSS_W'(c_reg[i]);
                    end
                    if (c_zero) begin
                        // Zero vector: zero unit normal, degenerate status.
                        status_reg <= 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            u_reg[i] <= '0;
                        end
                        state_reg <= (op_reg == CMD_TRI) ? ST_CRD : ST_OUT;
                    end else begin
                        state_reg <= ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    // Scale all magnitudes until the largest is below 2^MAG_W.
                    if (mag_big) begin
                        for (int i = 0; i < 3; i++) begin
                            mag_reg[i] <= mag_reg[i] >> 1;
                        end
                    end else begin
                        s_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg != 3'd0) begin
                        s_reg <= s_reg + SQ_W'(prod_reg);
                    end
                    if (cnt_reg == 3'd3) begin
                        state_reg <= ST_ROOT_GO;
                    end
                end
                ST_ROOT_GO: begin
                    state_reg <= ST_ROOT_WAIT;
                end
                ST_ROOT_WAIT: begin
                    if (sd_done) begin
                        for (int i = 0; i < 3; i++) begin
                            u_reg[i] <= sgn_reg[i] ? -NW'(sd_quot[i]) : NW'(sd_quot[i]);
                        end
                        state_reg <= (op_reg == CMD_TRI) ? ST_CRD : ST_OUT;
                    end
                end
                ST_CRD: begin
                    state_reg <= ST_CWR;
                end
                ST_CWR: begin
                    // Corners are updated in order so a repeated index sees its update.
                    k_reg <= k_reg + 1'b1;
                    state_reg <= (k_reg == 2'd2) ? ST_OUT : ST_CRD;
                end
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(MAX_VERTICES - 1)) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= status_reg;
                        if (op_reg == CMD_READ) begin
                            m_nx_reg <= u_reg[0];
                            m_ny_reg <= u_reg[1];
                            m_nz_reg <= u_reg[2];
                        end else begin
                            m_nx_reg <= '0;
                            m_ny_reg <= '0;
                            m_nz_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_normal_x = m_nx_reg;
    assign m_normal_y = m_ny_reg;
    assign m_normal_z = m_nz_reg;
    assign m_status   = m_status_reg;

endmodule
